FILE: sv/lfucp_pkg.sv
// Shared types and constants for the LFU/LRU write-back cache directory.
// Used by the directory cell and the top level; depends on nothing else.

package lfucp_pkg;

   // Field widths fixed by the interface.
   localparam int TAG_BITS   = 32;
   localparam int DATA_BITS  = 32;
   localparam int TOTAL_BITS = 32;
   localparam int CAP_BITS   = 4;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

   // One access request.
   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [DATA_BITS-1:0] write_data;
      logic                 write;
   } req_type;

   // One access result.
   typedef struct packed {
      logic                  hit;
      logic                  evicted;
      logic [TAG_BITS-1:0]   evicted_tag;
      logic                  writeback;
      logic [DATA_BITS-1:0]  writeback_data;
      logic [TOTAL_BITS-1:0] hit_count;
      logic [TOTAL_BITS-1:0] miss_count;
   } rsp_type;

   // Broadcast command from the controller to every cell.
   typedef struct packed {
      logic update;   // apply the access this cycle
      logic fill;     // selected cell takes a new entry (miss)
      logic write;    // access is a write
      logic age_all;  // every other valid entry ages by one
   } cell_cmd_type;

   // Access sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

FILE: sv/lfucp_cell.sv
// One directory cell: holds a single cache entry and one stage of the victim search chain.
// Depends on lfucp_pkg for the tag/data widths and the broadcast command type.

module lfucp_cell import lfucp_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int INDEX_BITS = 3,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic                  sel,
   input  logic [INDEX_BITS-1:0] age_below,
   input  logic [TAG_BITS-1:0]   req_tag,
   input  logic [DATA_BITS-1:0]  req_data,
   output logic                  match,
   output logic [INDEX_BITS-1:0] rank,
   input  logic                  cand_found_i,
   input  logic [COUNT_BITS-1:0] cand_count_i,
   input  logic [INDEX_BITS-1:0] cand_rank_i,
   input  logic [INDEX_BITS-1:0] cand_index_i,
   input  logic [TAG_BITS-1:0]   cand_tag_i,
   input  logic [DATA_BITS-1:0]  cand_data_i,
   input  logic                  cand_dirty_i,
   output logic                  cand_found_o,
   output logic [COUNT_BITS-1:0] cand_count_o,
   output logic [INDEX_BITS-1:0] cand_rank_o,
   output logic [INDEX_BITS-1:0] cand_index_o,
   output logic [TAG_BITS-1:0]   cand_tag_o,
   output logic [DATA_BITS-1:0]  cand_data_o,
   output logic                  cand_dirty_o
);

   // Entry storage.
   logic                  valid_ff, valid_in;
   logic                  dirty_ff, dirty_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [DATA_BITS-1:0]  data_ff, data_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [INDEX_BITS-1:0] rank_ff, rank_in;

   // Victim candidate handed to the next cell.
   logic                  cfound_ff, cfound_in;
   logic [COUNT_BITS-1:0] ccount_ff, ccount_in;
   logic [INDEX_BITS-1:0] crank_ff, crank_in;
   logic [INDEX_BITS-1:0] cindex_ff, cindex_in;
   logic [TAG_BITS-1:0]   ctag_ff, ctag_in;
   logic [DATA_BITS-1:0]  cdata_ff, cdata_in;
   logic                  cdirty_ff, cdirty_in;

   logic better;

   assign match = valid_ff && (tag_ff == req_tag);
   assign rank  = rank_ff;

   // This entry beats the incoming candidate if its count is lower, or on equal
   // counts if it is less recent.
   assign better = valid_ff &&
                   (!cand_found_i || (count_ff < cand_count_i) ||
                    ((count_ff == cand_count_i) && (rank_ff > cand_rank_i)));

   always_comb begin
      cfound_in = cand_found_i || valid_ff;
      if (better) begin
         ccount_in = count_ff;
         crank_in  = rank_ff;
         cindex_in = INDEX_BITS'(CELL_INDEX);
         ctag_in   = tag_ff;
         cdata_in  = data_ff;
         cdirty_in = dirty_ff;
      end else begin
         ccount_in = cand_count_i;
         crank_in  = cand_rank_i;
         cindex_in = cand_index_i;
         ctag_in   = cand_tag_i;
         cdata_in  = cand_data_i;
         cdirty_in = cand_dirty_i;
      end
   end

   // Entry update when the controller commits an access.
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      tag_in   = tag_ff;
      data_in  = data_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      if (cmd.update) begin
         if (sel) begin
            rank_in = '0;
            if (cmd.fill) begin
               valid_in = 1'b1;
               tag_in   = req_tag;
               count_in = COUNT_BITS'(1);
               data_in  = cmd.write ? req_data : '0;
               dirty_in = cmd.write;
            end else begin
               if (count_ff != '1) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
               if (cmd.write) begin
                  data_in  = req_data;
                  dirty_in = 1'b1;
               end
            end
         end else if (valid_ff && (cmd.age_all || (rank_ff < age_below))) begin
            rank_in = rank_ff + INDEX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         dirty_ff  <= 1'b0;
         cfound_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         dirty_ff  <= dirty_in;
         cfound_ff <= cfound_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff    <= tag_in;
      data_ff   <= data_in;
      count_ff  <= count_in;
      rank_ff   <= rank_in;
      ccount_ff <= ccount_in;
      crank_ff  <= crank_in;
      cindex_ff <= cindex_in;
      ctag_ff   <= ctag_in;
      cdata_ff  <= cdata_in;
      cdirty_ff <= cdirty_in;
   end

   assign cand_found_o = cfound_ff;
   assign cand_count_o = ccount_ff;
   assign cand_rank_o  = crank_ff;
   assign cand_index_o = cindex_ff;
   assign cand_tag_o   = ctag_ff;
   assign cand_data_o  = cdata_ff;
   assign cand_dirty_o = cdirty_ff;

endmodule

FILE: sv/lfu_lru_writeback_cache_policy.sv
// Top level of the LFU/LRU write-back cache directory: sequencer, counters and cell row.
// Depends on lfucp_pkg and lfucp_cell.

// An access is taken when start is high and busy is low, and its result shows on
// rsp_item for one cycle with rsp_valid high; there is no back-pressure, so the result
// must be captured in that cycle. A hit, or a miss while the directory holds fewer
// entries than the capacity, passes through lookup and commit before the result is
// registered. A miss that must evict passes through a scan between the two states:
// the least-used, least-recent victim is found by a candidate that moves through the
// row of ENTRIES cells one cell per clock. The capacity register may be written
// whenever busy is low; there is no clearing pass after reset.

module lfu_lru_writeback_cache_policy import lfucp_pkg::*; #(
   parameter int ENTRIES    = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_item,
   output logic                rsp_valid,
   output rsp_type             rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_BITS-1:0] csr_data
);

   localparam int INDEX_BITS = $clog2(ENTRIES);
   localparam int FILL_BITS  = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   req_type                req_ff, req_in;
   logic [CAP_BITS-1:0]    cap_ff, cap_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic                   hit_ff, hit_in;
   logic                   evict_ff, evict_in;
   logic [INDEX_BITS-1:0]  hit_idx_ff, hit_idx_in;
   logic [INDEX_BITS-1:0]  hit_rank_ff, hit_rank_in;
   logic [INDEX_BITS-1:0]  scan_ff, scan_in;
   logic [TOTAL_BITS-1:0]  hits_ff, hits_in;
   logic [TOTAL_BITS-1:0]  misses_ff, misses_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // Sequencer outputs.
   logic do_lookup;
   logic do_scan;
   logic do_commit;

   // Cell row wiring.
   cell_cmd_type          cmd;
   logic [ENTRIES-1:0]    sel;
   logic [ENTRIES-1:0]    match;
   logic [INDEX_BITS-1:0] rank [ENTRIES];
   logic [INDEX_BITS-1:0] age_below;
   logic [INDEX_BITS-1:0] slot;

   logic                  c_found [ENTRIES+1];
   logic [COUNT_BITS-1:0] c_count [ENTRIES+1];
   logic [INDEX_BITS-1:0] c_rank  [ENTRIES+1];
   logic [INDEX_BITS-1:0] c_index [ENTRIES+1];
   logic [TAG_BITS-1:0]   c_tag   [ENTRIES+1];
   logic [DATA_BITS-1:0]  c_data  [ENTRIES+1];
   logic                  c_dirty [ENTRIES+1];

   logic                  any_match;
   logic [INDEX_BITS-1:0] match_idx;
   logic [INDEX_BITS-1:0] match_rank;
   logic [31:0]           cap_wide;
   logic [31:0]           eff_cap;
   logic                  full;

   // Head of the candidate chain: no entry yet.
   assign c_found[0] = 1'b0;
   assign c_count[0] = '0;
   assign c_rank[0]  = '0;
   assign c_index[0] = '0;
   assign c_tag[0]   = '0;
   assign c_data[0]  = '0;
   assign c_dirty[0] = 1'b0;

   // Row of directory cells.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfucp_cell #(
         .CELL_INDEX (g),
         .INDEX_BITS (INDEX_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .sel          (sel[g]),
         .age_below    (age_below),
         .req_tag      (req_ff.tag),
         .req_data     (req_ff.write_data),
         .match        (match[g]),
         .rank         (rank[g]),
         .cand_found_i (c_found[g]),
         .cand_count_i (c_count[g]),
         .cand_rank_i  (c_rank[g]),
         .cand_index_i (c_index[g]),
         .cand_tag_i   (c_tag[g]),
         .cand_data_i  (c_data[g]),
         .cand_dirty_i (c_dirty[g]),
         .cand_found_o (c_found[g+1]),
         .cand_count_o (c_count[g+1]),
         .cand_rank_o  (c_rank[g+1]),
         .cand_index_o (c_index[g+1]),
         .cand_tag_o   (c_tag[g+1]),
         .cand_data_o  (c_data[g+1]),
         .cand_dirty_o (c_dirty[g+1])
      );
   end

   // Tags of valid entries are distinct, so at most one cell matches; OR the
   // masked index and rank together.
   always_comb begin
      any_match  = |match;
      match_idx  = '0;
      match_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            match_idx  = match_idx | INDEX_BITS'(i);
            match_rank = match_rank | rank[i];
         end
      end
   end

   // Effective capacity: zero counts as one, values above the row size are clipped.
   assign cap_wide = 32'(cap_ff);
   always_comb begin
      if (cap_wide == 32'd0) begin
         eff_cap = 32'd1;
      end else if (cap_wide > 32'(ENTRIES)) begin
         eff_cap = 32'(ENTRIES);
      end else begin
         eff_cap = cap_wide;
      end
   end
   assign full = 32'(fill_ff) >= eff_cap;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!any_match && full) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_SCAN: begin
            if (scan_ff == INDEX_BITS'(ENTRIES - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy      = 1'b1;
      do_lookup = 1'b0;
      do_scan   = 1'b0;
      do_commit = 1'b0;
      unique case (state_ff)
         ST_IDLE:   busy      = 1'b0;
         ST_LOOKUP: do_lookup = 1'b1;
         ST_SCAN:   do_scan   = 1'b1;
         ST_COMMIT: do_commit = 1'b1;
         default:   busy      = 1'b1;
      endcase
   end

   assign csr_ready = !busy;

   // Commit command: a hit promotes its slot; an eviction reuses the victim slot and
   // ages those more recent than it; a plain fill takes the next free slot and ages all.
   always_comb begin
      if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (evict_ff) begin
         slot = c_index[ENTRIES];
      end else begin
         slot = fill_ff[INDEX_BITS-1:0];
      end
      age_below   = hit_ff ? hit_rank_ff : c_rank[ENTRIES];
      cmd.update  = do_commit;
      cmd.fill    = !hit_ff;
      cmd.write   = req_ff.write;
      cmd.age_all = !hit_ff && !evict_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         sel[i] = (slot == INDEX_BITS'(i));
      end
   end

   // Request capture, lookup result, counters and result register.
   always_comb begin
      req_in       = req_ff;
      cap_in       = cap_ff;
      fill_in      = fill_ff;
      hit_in       = hit_ff;
      evict_in     = evict_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      scan_in      = '0;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (!busy && start) begin
         req_in = req_item;
      end
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
      if (do_lookup) begin
         hit_in      = any_match;
         evict_in    = !any_match && full;
         hit_idx_in  = match_idx;
         hit_rank_in = match_rank;
      end
      if (do_scan) begin
         scan_in = scan_ff + INDEX_BITS'(1);
      end
      if (do_commit) begin
         if (hit_ff) begin
            if (hits_ff != '1) begin
               hits_in = hits_ff + TOTAL_BITS'(1);
            end
         end else begin
            if (misses_ff != '1) begin
               misses_in = misses_ff + TOTAL_BITS'(1);
            end
            if (!evict_ff) begin
               fill_in = fill_ff + FILL_BITS'(1);
            end
         end
         rsp_valid_in          = 1'b1;
         rsp_in.hit            = hit_ff;
         rsp_in.evicted        = evict_ff;
         rsp_in.evicted_tag    = evict_ff ? c_tag[ENTRIES] : '0;
         rsp_in.writeback      = evict_ff && c_dirty[ENTRIES];
         rsp_in.writeback_data = (evict_ff && c_dirty[ENTRIES]) ? c_data[ENTRIES] : '0;
         rsp_in.hit_count      = hits_in;
         rsp_in.miss_count     = misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         fill_ff      <= '0;
         scan_ff      <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hit_ff      <= hit_in;
      evict_ff    <= evict_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The directory never holds more entries than it has cells.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(ENTRIES))
      else $error("fill count exceeds the number of cells");

   // A result is shown only once the access has finished.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while an access is in progress");

   // An eviction only happens on a miss, and a write-back only with an eviction.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.evicted |-> !rsp_item.hit)
      else $error("eviction reported on a hit");

   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.writeback |-> rsp_item.evicted)
      else $error("write-back reported without eviction");

   // An evicting miss only commits after the candidate has crossed the whole row.
   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      do_commit && evict_ff |-> $past(do_scan) && c_found[ENTRIES])
      else $error("victim committed before the search completed");

   // Each hit result advances the hit total unless the total is saturated.
   a_hit_total: assert property (@(posedge clock) disable iff (reset)
      do_commit && hit_ff && (hits_ff != '1) |=> hits_ff == $past(hits_ff) + TOTAL_BITS'(1))
      else $error("hit total did not advance on a hit");

endmodule
